>>> sv/base32_stream_encoder_macros.svh
// Assertion helpers shared by the encoder modules.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define B32E_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define B32E_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/b32e_pkg.sv
package b32e_pkg;

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [4:0] SYMBOL_MASK = 5'h1F;
  localparam logic [2:0] GROUP_BYTES = 3'd5;
  localparam logic [2:0] MAX_RESIDUE = 3'd4;

  // Work for one accepted byte, in emission order:
  // sym0, sym1 (if two), flush (if flush), then pads '=' characters.
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic       two;
    logic [4:0] flush_sym;
    logic       flush;
    logic [2:0] pads;
  } b32e_job_t;

  typedef enum logic [1:0] {
    PH_SYM0,
    PH_SYM1,
    PH_FLUSH,
    PH_PAD
  } b32e_phase_t;

  // RFC 4648 alphabet: A-Z then 2-7.
  function automatic logic [7:0] sym_char(input logic [4:0] code);
    logic [7:0] c;
    c = {3'b000, code};
    if (code < 5'd26) begin
      sym_char = 8'h41 + c;
    end else begin
      sym_char = 8'h32 + c - 8'd26;
    end
  endfunction

  // '=' count after the final byte, by bytes taken in the group (1..5).
  function automatic logic [2:0] pad_count(input logic [2:0] pos);
    unique case (pos)
      3'd1:    pad_count = 3'd6;
      3'd2:    pad_count = 3'd4;
      3'd3:    pad_count = 3'd3;
      3'd4:    pad_count = 3'd1;
      default: pad_count = 3'd0;
    endcase
  endfunction

endpackage

>>> sv/base32_stream_encoder.sv
// Streaming Base32 encoder (RFC 4648 alphabet). Each input transaction
// carries one plain byte and a final_byte mark; each output transaction
// carries one ASCII character (A-Z, 2-7 or '=') and run_last, set on the
// last character that its byte causes. A non-final byte yields one or two
// characters; the final byte also flushes the leftover bits as one
// zero-filled character and pads with '=' to an eight-character boundary,
// then the encoder is back in its reset state. Rate: the character
// sequencer in the back end drives one character per cycle while a job
// is queued and the receiver does not stall. The front end computes a
// byte's whole work in the cycle that it accepts it and takes a new byte
// every cycle while the two-entry job queue has room. The output register
// holds the current character while the receiver stalls; the next
// character is loaded in the same cycle that the current one is taken, so
// there is no bubble between characters. No clearing pass after reset.
module base32_stream_encoder import b32e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last
);

  b32e_job_t new_job;
  b32e_job_t head_job;
  logic      push;
  logic      full;
  logic      head_valid;
  logic      pop;

  // Hold off the source only when the job queue is full.
  assign in_stall = full;
  assign push     = in_valid && !full;

  // Front end: split the byte into symbols and track the group state.
  b32e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .push       (push),
    .job        (new_job)
  );

  // Decouple the front end from the character sequencer.
  b32e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (new_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: advance through each job one character per cycle while the receiver does not stall.
  b32e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .run_last   (run_last)
  );

endmodule

>>> sv/b32e_front.sv
`include "base32_stream_encoder_macros.svh"

module b32e_front import b32e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  input  logic       push,
  output b32e_job_t  job
);

  logic [3:0]  residue_bits;
  logic [2:0]  residue_count;
  logic [2:0]  group_position;
  logic [3:0]  residue_bits_next;
  logic [2:0]  residue_count_next;
  logic [2:0]  group_position_next;

  logic [11:0] acc;
  logic [2:0]  rem;
  logic [3:0]  rem_mask;
  logic [3:0]  kept;
  logic [2:0]  pos;
  logic [7:0]  flush_wide;

  always_comb begin
    acc = {residue_bits, data_byte};
    job.two = (residue_count >= 3'd2);
    rem = job.two ? residue_count - 3'd2 : residue_count + 3'd3;
    job.sym0 = 5'(acc >> (residue_count + 3'd3)) & SYMBOL_MASK;
    job.sym1 = 5'(acc >> (residue_count - 3'd2)) & SYMBOL_MASK;
    rem_mask = 4'((5'd1 << rem) - 5'd1);
    kept = data_byte[3:0] & rem_mask;
    flush_wide = {4'd0, kept} << (3'd5 - rem);
    job.flush_sym = flush_wide[4:0];
    job.flush = final_byte && (rem != 3'd0);
    pos = group_position + 3'd1;
    job.pads = final_byte ? pad_count(pos) : 3'd0;

    if (final_byte) begin
      residue_bits_next   = '0;
      residue_count_next  = '0;
      group_position_next = '0;
    end else begin
      residue_bits_next   = kept;
      residue_count_next  = rem;
      group_position_next = (pos >= GROUP_BYTES) ? 3'd0 : pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      residue_bits   <= '0;
      residue_count  <= '0;
      group_position <= '0;
    end else if (push) begin
      residue_bits   <= residue_bits_next;
      residue_count  <= residue_count_next;
      group_position <= group_position_next;
    end
  end

  `B32E_ASSERT_NOW(a_residue_range, clk, rst, 1'b1, residue_count <= MAX_RESIDUE, "residue count out of range")
  `B32E_ASSERT_NOW(a_group_range, clk, rst, 1'b1, group_position < GROUP_BYTES, "group position out of range")
  `B32E_ASSERT_NEXT(a_final_clears, clk, rst, push && final_byte, (residue_count == 3'd0) && (group_position == 3'd0), "state not cleared after final byte")

endmodule

>>> sv/b32e_queue.sv
module b32e_queue import b32e_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b32e_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output b32e_job_t head_job
);

  b32e_job_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && head_valid)) begin
      count_next = count + 2'd1;
    end else if (!push && pop && head_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && head_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

endmodule

>>> sv/b32e_back.sv
`include "base32_stream_encoder_macros.svh"

module b32e_back import b32e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  b32e_job_t  head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       run_last
);

  b32e_phase_t phase;
  b32e_phase_t phase_next;
  logic [2:0]  pad_left;
  logic [2:0]  pad_left_next;
  logic [7:0]  char_next;
  logic        last_next;
  logic        load;
  logic        emit;

  assign load = !out_valid || !out_stall;
  assign emit = load && head_valid;
  assign pop  = emit && last_next;

  always_comb begin
    phase_next    = phase;
    pad_left_next = pad_left;
    char_next     = PAD_CHAR;
    last_next     = 1'b0;
    unique case (phase)
      PH_SYM0: begin
        char_next = sym_char(head_job.sym0);
        last_next = !head_job.two && !head_job.flush && (head_job.pads == 3'd0);
        pad_left_next = head_job.pads;
        if (head_job.two) begin
          phase_next = PH_SYM1;
        end else if (head_job.flush) begin
          phase_next = PH_FLUSH;
        end else begin
          phase_next = PH_PAD;
        end
      end
      PH_SYM1: begin
        char_next = sym_char(head_job.sym1);
        last_next = !head_job.flush && (head_job.pads == 3'd0);
        pad_left_next = head_job.pads;
        phase_next = head_job.flush ? PH_FLUSH : PH_PAD;
      end
      PH_FLUSH: begin
        char_next = sym_char(head_job.flush_sym);
        last_next = (head_job.pads == 3'd0);
        pad_left_next = head_job.pads;
        phase_next = PH_PAD;
      end
      PH_PAD: begin
        char_next = PAD_CHAR;
        last_next = (pad_left == 3'd1);
        pad_left_next = pad_left - 3'd1;
        phase_next = PH_PAD;
      end
      default: begin
        phase_next = PH_SYM0;
      end
    endcase
    // Restart at the first symbol once the job's last character goes out.
    if (last_next) begin
      phase_next = PH_SYM0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYM0;
      pad_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        phase    <= phase_next;
        pad_left <= pad_left_next;
      end
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= char_next;
      run_last <= last_next;
    end
  end

  `B32E_ASSERT_NOW(a_pad_nonzero, clk, rst, (phase == PH_PAD) && head_valid, pad_left != 3'd0, "pad phase with no pads left")
  `B32E_ASSERT_NOW(a_job_held, clk, rst, phase != PH_SYM0, head_valid, "job left the queue mid-run")
  `B32E_ASSERT_NEXT(a_run_restart, clk, rst, pop, phase == PH_SYM0, "sequencer did not restart after run")

endmodule
